>>> sv/apss_pkg.sv
// Shared types, codes and constants of the ATA PIO sector sequencer.
`timescale 1ns / 1ps

package apss_pkg;

	// Sector geometry and the front-to-back job queue
	localparam int WORDS_PER_SECTOR = 256;
	localparam int WC_W             = $clog2(WORDS_PER_SECTOR + 1);
	localparam int Q_DEPTH          = 4;
	localparam int Q_PTR_W          = $clog2(Q_DEPTH);
	localparam int Q_CNT_W          = $clog2(Q_DEPTH + 1);

	// Field widths
	localparam int POLL_W  = 20;
	localparam int SETTLE_W = 4;
	localparam int LBA_W   = 28;
	localparam int WORD_W  = 16;
	localparam int PORT_W  = 9;
	localparam int JDATA_W = 24;
	localparam int CFG_IDX_W = 2;

	// Register file indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_READS = 2'd1;

	localparam logic [POLL_W-1:0]   POLL_LIMIT_RST   = 20'd1000000;
	localparam logic [SETTLE_W-1:0] SETTLE_READS_RST = 4'd4;

	// Request types
	localparam logic [1:0] REQ_CMD   = 2'd0;
	localparam logic [1:0] REQ_REPLY = 2'd1;
	localparam logic [1:0] REQ_WORD  = 2'd2;

	// Bus ports and protocol bytes
	localparam logic [PORT_W-1:0] BASE_PRI = 9'h1F0;
	localparam logic [PORT_W-1:0] BASE_SEC = 9'h170;
	localparam logic [2:0] OFS_COUNT  = 3'd2;
	localparam logic [2:0] OFS_LBA0   = 3'd3;
	localparam logic [2:0] OFS_LBA1   = 3'd4;
	localparam logic [2:0] OFS_LBA2   = 3'd5;
	localparam logic [2:0] OFS_DRIVE  = 3'd6;
	localparam logic [2:0] OFS_CMD    = 3'd7;
	localparam logic [7:0] SEL_MASTER = 8'hE0;
	localparam logic [7:0] SEL_SLAVE  = 8'hF0;
	localparam logic [7:0] ST_ABSENT  = 8'hFF;
	localparam int         ST_BSY_BIT = 7;
	localparam int         ST_DRQ_BIT = 3;
	localparam logic [7:0] CMD_READ   = 8'h20;
	localparam logic [7:0] CMD_WRITE  = 8'h30;
	localparam logic [7:0] CMD_FLUSH  = 8'hE7;

	typedef enum logic [2:0] {
		KIND_BWR  = 3'd0,
		KIND_BRD  = 3'd1,
		KIND_WRD  = 3'd2,
		KIND_WWR  = 3'd3,
		KIND_HOST = 3'd4,
		KIND_DONE = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		DONE_OK        = 3'd0,
		DONE_NO_DRIVE  = 3'd1,
		DONE_BSY_TMO   = 3'd2,
		DONE_DRQ_TMO   = 3'd3,
		DONE_FLUSH_TMO = 3'd4
	} done_t;

	// Job classes handed from the front to the back
	typedef enum logic [2:0] {
		OP_STATUS = 3'd0,  // status read
		OP_DONE   = 3'd1,  // completion
		OP_SELECT = 3'd2,  // drive select, status read
		OP_ISSUE  = 3'd3,  // count, address, command, status read
		OP_WRD    = 3'd4,  // data word read
		OP_HOST   = 3'd5,  // word to host, then next read or completion
		OP_WWR    = 3'd6   // data word write, optional flush and status read
	} op_t;

	typedef struct packed {
		op_t                op;
		logic               sec;   // secondary channel
		logic               flag;  // write command / final word
		done_t              code;
		logic [JDATA_W-1:0] data;
	} job_t;

endpackage

>>> sv/apss_front.sv
// Front end: accepts items, tracks the transfer phase and queues jobs.
`timescale 1ns / 1ps

module apss_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [1:0]                          req_type,
	input  logic                                is_write,
	input  logic [1:0]                          drive_index,
	input  logic [apss_pkg::LBA_W-1:0]          block_address,
	input  logic [apss_pkg::WORD_W-1:0]         reply_value,
	input  logic [apss_pkg::WORD_W-1:0]         write_word,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [apss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [apss_pkg::POLL_W-1:0]         cfg_data,
	output logic                                push,
	output apss_pkg::job_t                      job,
	input  logic                                q_full
);
	import apss_pkg::*;

	typedef enum logic [8:0] {
		PH_IDLE    = 9'b000000001,
		PH_SETTLE  = 9'b000000010,
		PH_PRESENT = 9'b000000100,
		PH_BSY     = 9'b000001000,
		PH_DRQ     = 9'b000010000,
		PH_RDATA   = 9'b000100000,
		PH_WDATA   = 9'b001000000,
		PH_FSETTLE = 9'b010000000,
		PH_FBSY    = 9'b100000000
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [POLL_W-1:0]    poll_count_q, poll_count_d, poll_inc;
	logic [WC_W-1:0]      word_count_q, word_count_d, wc_inc;
	logic [SETTLE_W-1:0]  settle_count_q, settle_count_d;
	logic [1:0]           cur_drive_q, cur_drive_d;
	logic                 cur_write_q, cur_write_d;
	logic [LBA_W-1:0]     cur_block_q, cur_block_d;
	logic [POLL_W-1:0]    poll_limit_q;
	logic [SETTLE_W-1:0]  settle_reads_q;
	logic                 accept, expired, last_word;

	assign item_ready = !q_full;
	assign cfg_ready  = 1'b1;
	assign accept     = item_valid && item_ready;
	assign poll_inc   = poll_count_q + POLL_W'(1);
	assign expired    = poll_inc >= poll_limit_q;
	assign wc_inc     = word_count_q + WC_W'(1);
	assign last_word  = wc_inc >= WC_W'(WORDS_PER_SECTOR);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_limit_q   <= POLL_LIMIT_RST;
			settle_reads_q <= SETTLE_READS_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_POLL_LIMIT)
				poll_limit_q <= cfg_data;
			else if (cfg_index == CFG_SETTLE_READS)
				settle_reads_q <= cfg_data[SETTLE_W-1:0];
		end
	end

	// Classify the beat against the phase and build its job
	always_comb begin
		phase_d        = phase_q;
		poll_count_d   = poll_count_q;
		word_count_d   = word_count_q;
		settle_count_d = settle_count_q;
		cur_drive_d    = cur_drive_q;
		cur_write_d    = cur_write_q;
		cur_block_d    = cur_block_q;
		push           = 1'b0;
		job.op         = OP_STATUS;
		job.sec        = cur_drive_q[1];
		job.flag       = cur_write_q;
		job.code       = DONE_OK;
		job.data       = '0;
		if (accept) begin
			unique case (req_type)
				REQ_CMD: begin
					if (phase_q == PH_IDLE) begin
						cur_write_d = is_write;
						cur_drive_d = drive_index;
						cur_block_d = block_address;
						push        = 1'b1;
						job.op      = OP_SELECT;
						job.sec     = drive_index[1];
						job.data    = JDATA_W'((drive_index[0] ? SEL_SLAVE : SEL_MASTER)
						              | {4'h0, block_address[27:24]});
						if (settle_reads_q != '0) begin
							settle_count_d = settle_reads_q - SETTLE_W'(1);
							phase_d        = PH_SETTLE;
						end else if (is_write) begin
							poll_count_d = '0;
							phase_d      = PH_BSY;
						end else begin
							phase_d = PH_PRESENT;
						end
					end
				end
				REQ_REPLY: begin
					unique case (phase_q)
						PH_SETTLE, PH_FSETTLE: begin
							push = 1'b1;
							if (settle_count_q != '0) begin
								settle_count_d = settle_count_q - SETTLE_W'(1);
							end else if (phase_q == PH_SETTLE) begin
								if (cur_write_q) begin
									poll_count_d = '0;
									phase_d      = PH_BSY;
								end else begin
									phase_d = PH_PRESENT;
								end
							end else begin
								poll_count_d = '0;
								phase_d      = PH_FBSY;
							end
						end
						PH_PRESENT: begin
							push = 1'b1;
							if (reply_value[7:0] == ST_ABSENT) begin
								job.op   = OP_DONE;
								job.code = DONE_NO_DRIVE;
								phase_d  = PH_IDLE;
							end else begin
								poll_count_d = '0;
								phase_d      = PH_BSY;
							end
						end
						PH_BSY: begin
							push = 1'b1;
							if (!reply_value[ST_BSY_BIT]) begin
								job.op       = OP_ISSUE;
								job.data     = cur_block_q[JDATA_W-1:0];
								poll_count_d = '0;
								phase_d      = PH_DRQ;
							end else begin
								poll_count_d = poll_inc;
								if (expired) begin
									job.op   = OP_DONE;
									job.code = DONE_BSY_TMO;
									phase_d  = PH_IDLE;
								end
							end
						end
						PH_DRQ: begin
							if (reply_value[ST_DRQ_BIT]) begin
								word_count_d = '0;
								if (cur_write_q) begin
									phase_d = PH_WDATA;
								end else begin
									push    = 1'b1;
									job.op  = OP_WRD;
									phase_d = PH_RDATA;
								end
							end else begin
								push         = 1'b1;
								poll_count_d = poll_inc;
								if (expired) begin
									job.op   = OP_DONE;
									job.code = DONE_DRQ_TMO;
									phase_d  = PH_IDLE;
								end
							end
						end
						PH_RDATA: begin
							push         = 1'b1;
							job.op       = OP_HOST;
							job.flag     = last_word;
							job.data     = JDATA_W'(reply_value);
							word_count_d = wc_inc;
							if (last_word)
								phase_d = PH_IDLE;
						end
						PH_FBSY: begin
							push = 1'b1;
							if (!reply_value[ST_BSY_BIT]) begin
								job.op  = OP_DONE;
								phase_d = PH_IDLE;
							end else begin
								poll_count_d = poll_inc;
								if (expired) begin
									job.op   = OP_DONE;
									job.code = DONE_FLUSH_TMO;
									phase_d  = PH_IDLE;
								end
							end
						end
						default: ;
					endcase
				end
				REQ_WORD: begin
					if (phase_q == PH_WDATA) begin
						push         = 1'b1;
						job.op       = OP_WWR;
						job.flag     = last_word;
						job.data     = JDATA_W'(write_word);
						word_count_d = wc_inc;
						if (last_word) begin
							if (settle_reads_q != '0) begin
								settle_count_d = settle_reads_q - SETTLE_W'(1);
								phase_d        = PH_FSETTLE;
							end else begin
								poll_count_d = '0;
								phase_d      = PH_FBSY;
							end
						end
					end
				end
				// unknown request type: taken and dropped
				default: ;
			endcase
		end
	end

	// Transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			poll_count_q   <= '0;
			word_count_q   <= '0;
			settle_count_q <= '0;
			cur_drive_q    <= '0;
			cur_write_q    <= 1'b0;
			cur_block_q    <= '0;
		end else begin
			phase_q        <= phase_d;
			poll_count_q   <= poll_count_d;
			word_count_q   <= word_count_d;
			settle_count_q <= settle_count_d;
			cur_drive_q    <= cur_drive_d;
			cur_write_q    <= cur_write_d;
			cur_block_q    <= cur_block_d;
		end
	end

	// A completion job always returns the sequencer to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push && job.op == OP_DONE) |=> (phase_q == PH_IDLE))
		else $error("completion queued without return to idle");

	// The read data count never reaches a full sector while still reading
	a_rdata_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RDATA) |-> (word_count_q < WC_W'(WORDS_PER_SECTOR)))
		else $error("read word count overran the sector");

	// No job is pushed into a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into full queue");

endmodule

>>> sv/apss_fifo.sv
// Short job queue between the front and back ends.
`timescale 1ns / 1ps

module apss_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  apss_pkg::job_t  push_job,
	input  logic            pop,
	output apss_pkg::job_t  head_job,
	output logic            head_valid,
	output logic            full
);
	import apss_pkg::*;

	job_t                entries_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;
	logic                do_pop;

	assign head_valid = count_q != '0;
	assign full       = count_q == Q_CNT_W'(Q_DEPTH);
	assign head_job   = entries_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_job;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			if (push && !do_pop)
				count_q <= count_q + Q_CNT_W'(1);
			else if (!push && do_pop)
				count_q <= count_q - Q_CNT_W'(1);
		end
	end

endmodule

>>> sv/apss_back.sv
// Back end: expands queued jobs into bus access and completion beats.
`timescale 1ns / 1ps

module apss_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  apss_pkg::job_t               head_job,
	input  logic                         head_valid,
	output logic                         pop,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [2:0]                   result_kind,
	output logic [apss_pkg::PORT_W-1:0]  bus_port,
	output logic [apss_pkg::WORD_W-1:0]  out_data,
	output logic [2:0]                   done_code,
	output logic                         last
);
	import apss_pkg::*;

	logic [2:0]         idx_q;
	logic               valid_q;
	kind_t              kind_q, kind_c;
	logic [PORT_W-1:0]  port_q, port_c, base;
	logic [WORD_W-1:0]  data_q, data_c;
	done_t              code_q, code_c;
	logic               last_q, last_c;
	logic               load;

	assign base = head_job.sec ? BASE_SEC : BASE_PRI;
	assign load = head_valid && (!valid_q || result_ready);
	assign pop  = load && last_c;

	// Beat of the head job at the current index
	always_comb begin
		kind_c = KIND_BRD;
		port_c = base + PORT_W'(OFS_CMD);
		data_c = '0;
		code_c = DONE_OK;
		last_c = 1'b1;
		unique case (head_job.op)
			OP_STATUS: ;
			OP_DONE: begin
				kind_c = KIND_DONE;
				port_c = '0;
				code_c = head_job.code;
			end
			OP_SELECT: begin
				last_c = idx_q == 3'd1;
				if (idx_q == 3'd0) begin
					kind_c = KIND_BWR;
					port_c = base + PORT_W'(OFS_DRIVE);
					data_c = {8'h00, head_job.data[7:0]};
				end
			end
			OP_ISSUE: begin
				last_c = idx_q == 3'd5;
				unique case (idx_q)
					3'd0: begin
						kind_c = KIND_BWR;
						port_c = base + PORT_W'(OFS_COUNT);
						data_c = WORD_W'(1);
					end
					3'd1: begin
						kind_c = KIND_BWR;
						port_c = base + PORT_W'(OFS_LBA0);
						data_c = {8'h00, head_job.data[7:0]};
					end
					3'd2: begin
						kind_c = KIND_BWR;
						port_c = base + PORT_W'(OFS_LBA1);
						data_c = {8'h00, head_job.data[15:8]};
					end
					3'd3: begin
						kind_c = KIND_BWR;
						port_c = base + PORT_W'(OFS_LBA2);
						data_c = {8'h00, head_job.data[23:16]};
					end
					3'd4: begin
						kind_c = KIND_BWR;
						data_c = {8'h00, head_job.flag ? CMD_WRITE : CMD_READ};
					end
					default: ;
				endcase
			end
			OP_WRD: begin
				kind_c = KIND_WRD;
				port_c = base;
			end
			OP_HOST: begin
				last_c = idx_q == 3'd1;
				if (idx_q == 3'd0) begin
					kind_c = KIND_HOST;
					port_c = '0;
					data_c = head_job.data[WORD_W-1:0];
				end else if (head_job.flag) begin
					kind_c = KIND_DONE;
					port_c = '0;
				end else begin
					kind_c = KIND_WRD;
					port_c = base;
				end
			end
			OP_WWR: begin
				last_c = head_job.flag ? (idx_q == 3'd2) : 1'b1;
				if (idx_q == 3'd0) begin
					kind_c = KIND_WWR;
					port_c = base;
					data_c = head_job.data[WORD_W-1:0];
				end else if (idx_q == 3'd1) begin
					kind_c = KIND_BWR;
					data_c = {8'h00, CMD_FLUSH};
				end
			end
			default: ;
		endcase
	end

	// Beat index within the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= last_c ? 3'd0 : idx_q + 3'd1;
			if (load)
				valid_q <= 1'b1;
			else if (result_ready)
				valid_q <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_c;
			port_q <= port_c;
			data_q <= data_c;
			code_q <= code_c;
			last_q <= last_c;
		end
	end

	assign result_valid = valid_q;
	assign result_kind  = kind_q;
	assign bus_port     = port_q;
	assign out_data     = data_q;
	assign done_code    = code_q;
	assign last         = last_q;

endmodule

>>> sv/ata_pio_sector_sequencer.sv
// Top level of the ATA PIO LBA28 single-sector sequencer.
// Usage: the item channel takes commands (req_type 0), bus read replies
// (req_type 1) and host data words for a write (req_type 2). Each beat
// that fits the current phase produces zero to six result beats on the
// result channel, the final one flagged by last: byte/word bus accesses,
// host data words and one completion with done_code per transfer. Beats
// that do not fit the phase are taken and dropped.
// Order: the front end classifies an item in the cycle it is taken and
// queues a job; the back end then registers the first result beat.
// Throughput: one item per cycle while the four-entry job queue has room;
// the back end issues one result beat per cycle while the receiver is
// ready, and a job has at most six beats.
// A stalled receiver backs results up into the queue; once it is full,
// item_ready drops until the back end drains an entry.
// Configuration (cfg_index 0 poll_limit, 1 settle_reads) is always ready.
// The user must write it only while no beat is in flight; the block does
// not enforce it. settle_reads is taken when a delay starts; poll_limit
// is compared at every poll. Reset: arst_n clears the queue, the result
// valid and the phase, and loads poll_limit 1000000 and settle_reads 4.
`timescale 1ns / 1ps

module ata_pio_sector_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [1:0]                          req_type,
	input  logic                                is_write,
	input  logic [1:0]                          drive_index,
	input  logic [apss_pkg::LBA_W-1:0]          block_address,
	input  logic [apss_pkg::WORD_W-1:0]         reply_value,
	input  logic [apss_pkg::WORD_W-1:0]         write_word,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [apss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [apss_pkg::POLL_W-1:0]         cfg_data,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [2:0]                          result_kind,
	output logic [apss_pkg::PORT_W-1:0]         bus_port,
	output logic [apss_pkg::WORD_W-1:0]         out_data,
	output logic [2:0]                          done_code,
	output logic                                last
);
	import apss_pkg::*;

	job_t  push_job, head_job;
	logic  push, pop, head_valid, q_full;

	apss_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.req_type      (req_type),
		.is_write      (is_write),
		.drive_index   (drive_index),
		.block_address (block_address),
		.reply_value   (reply_value),
		.write_word    (write_word),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.push          (push),
		.job           (push_job),
		.q_full        (q_full)
	);

	apss_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_job   (head_job),
		.head_valid (head_valid),
		.full       (q_full)
	);

	apss_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_job     (head_job),
		.head_valid   (head_valid),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_kind  (result_kind),
		.bus_port     (bus_port),
		.out_data     (out_data),
		.done_code    (done_code),
		.last         (last)
	);

endmodule

>>> test/ata_pio_sector_sequencer_tb.sv
// Self-checking testbench for the ATA PIO sector sequencer: it plays bus and host and predicts each beat.
`timescale 1ns / 1ps

module ata_pio_sector_sequencer_tb;
	import apss_pkg::*;

	localparam logic [1:0]           REQ_BAD     = 2'd3;  // no such request
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;  // unmapped register
	localparam int                   DRAIN_PAD   = 16;
	localparam int                   STALL_LIMIT = 2000;

	typedef enum logic [3:0] {
		S_IDLE, S_SETTLE, S_PRESENT, S_BUSY, S_DREQ, S_RDATA, S_WDATA, S_FSETTLE, S_FBUSY
	} seq_phase_t;

	typedef struct packed {
		logic [1:0]       req;
		logic             wr;
		logic [1:0]       drv;
		logic [LBA_W-1:0] lba;
		logic [WORD_W-1:0] reply;
		logic [WORD_W-1:0] word;
	} item_t;

	typedef struct packed {
		kind_t             kind;
		logic [PORT_W-1:0] port;
		logic [WORD_W-1:0] data;
		done_t             code;
		logic              last;
	} beat_t;

	// Sequencer model and store of beats still owed by the block
	class sector_scoreboard;
		logic [POLL_W-1:0]   poll_limit;
		logic [SETTLE_W-1:0] settle_reads;
		seq_phase_t          phase;
		logic [POLL_W-1:0]   polls;
		logic [WC_W-1:0]     words;
		logic [SETTLE_W-1:0] settle_left;
		logic [1:0]          drive;
		logic                wr;
		logic [LBA_W-1:0]    lba;
		beat_t               pending[$];
		beat_t               step[$];
		int                  errors;
		int                  beats_seen;

		function new();
			poll_limit   = POLL_LIMIT_RST;
			settle_reads = SETTLE_READS_RST;
			phase        = S_IDLE;
			polls        = '0;
			words        = '0;
			settle_left  = '0;
			drive        = '0;
			wr           = 1'b0;
			lba          = '0;
			errors       = 0;
			beats_seen   = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [POLL_W-1:0] val);
			if (idx == CFG_POLL_LIMIT)
				poll_limit = val;
			else if (idx == CFG_SETTLE_READS)
				settle_reads = val[SETTLE_W-1:0];
		endfunction

		function logic [PORT_W-1:0] base();
			return drive[1] ? BASE_SEC : BASE_PRI;
		endfunction

		function void put(kind_t k, logic [PORT_W-1:0] p, logic [WORD_W-1:0] d, done_t c);
			step.push_back(beat_t'{kind: k, port: p, data: d, code: c, last: 1'b0});
		endfunction

		function void status_read(seq_phase_t nxt);
			put(KIND_BRD, base() + OFS_CMD, '0, DONE_OK);
			phase = nxt;
		endfunction

		function void complete(done_t c);
			put(KIND_DONE, '0, '0, c);
			phase = S_IDLE;
		endfunction

		function void start_poll(seq_phase_t nxt);
			polls = '0;
			status_read(nxt);
		endfunction

		function bit poll_expired();
			polls = polls + 1'b1;
			return polls >= poll_limit;
		endfunction

		function void after_select();
			if (wr)
				start_poll(S_BUSY);
			else
				status_read(S_PRESENT);
		endfunction

		// settle count is taken from the register when the delay starts
		function void begin_settle(seq_phase_t sp);
			if (settle_reads == 0) begin
				if (sp == S_SETTLE)
					after_select();
				else
					start_poll(S_FBUSY);
			end else begin
				settle_left = settle_reads - 1'b1;
				status_read(sp);
			end
		endfunction

		function void note_item(item_t it);
			logic [7:0] st;
			step.delete();
			st = it.reply[7:0];
			case (it.req)
			REQ_CMD: if (phase == S_IDLE) begin
				wr    = it.wr;
				drive = it.drv;
				lba   = it.lba;
				put(KIND_BWR, base() + OFS_DRIVE,
					{8'h00, (drive[0] ? SEL_SLAVE : SEL_MASTER) | {4'h0, lba[27:24]}}, DONE_OK);
				begin_settle(S_SETTLE);
			end
			REQ_REPLY: case (phase)
				S_SETTLE, S_FSETTLE: begin
					if (settle_left != 0) begin
						settle_left--;
						status_read(phase);
					end else if (phase == S_SETTLE)
						after_select();
					else
						start_poll(S_FBUSY);
				end
				// all-ones status: nothing on the cable
				S_PRESENT: begin
					if (st == ST_ABSENT)
						complete(DONE_NO_DRIVE);
					else
						start_poll(S_BUSY);
				end
				S_BUSY: begin
					if (!st[ST_BSY_BIT]) begin
						put(KIND_BWR, base() + OFS_COUNT, 16'd1, DONE_OK);
						put(KIND_BWR, base() + OFS_LBA0, {8'h00, lba[7:0]}, DONE_OK);
						put(KIND_BWR, base() + OFS_LBA1, {8'h00, lba[15:8]}, DONE_OK);
						put(KIND_BWR, base() + OFS_LBA2, {8'h00, lba[23:16]}, DONE_OK);
						put(KIND_BWR, base() + OFS_CMD, {8'h00, wr ? CMD_WRITE : CMD_READ}, DONE_OK);
						start_poll(S_DREQ);
					end else if (poll_expired())
						complete(DONE_BSY_TMO);
					else
						status_read(S_BUSY);
				end
				// a write goes quiet here until host words turn up
				S_DREQ: begin
					if (st[ST_DRQ_BIT]) begin
						words = '0;
						if (wr)
							phase = S_WDATA;
						else begin
							put(KIND_WRD, base(), '0, DONE_OK);
							phase = S_RDATA;
						end
					end else if (poll_expired())
						complete(DONE_DRQ_TMO);
					else
						status_read(S_DREQ);
				end
				S_RDATA: begin
					put(KIND_HOST, '0, it.reply, DONE_OK);
					words++;
					if (words >= WORDS_PER_SECTOR)
						complete(DONE_OK);
					else
						put(KIND_WRD, base(), '0, DONE_OK);
				end
				S_FBUSY: begin
					if (!st[ST_BSY_BIT])
						complete(DONE_OK);
					else if (poll_expired())
						complete(DONE_FLUSH_TMO);
					else
						status_read(S_FBUSY);
				end
				default: ;
			endcase
			REQ_WORD: if (phase == S_WDATA) begin
				put(KIND_WWR, base(), it.word, DONE_OK);
				words++;
				if (words >= WORDS_PER_SECTOR) begin
					put(KIND_BWR, base() + OFS_CMD, {8'h00, CMD_FLUSH}, DONE_OK);
					begin_settle(S_FSETTLE);
				end
			end
			default: ;
			endcase
			if (step.size() != 0)
				step[step.size() - 1].last = 1'b1;
			foreach (step[i])
				pending.push_back(step[i]);
		endfunction

		task flag(string msg);
			if (errors < 100)
				$display("%s", msg);
			errors++;
		endtask

		task check_result(beat_t got);
			beat_t want;
			beats_seen++;
			if (pending.size() == 0) begin
				flag($sformatf("beat %0d: kind %0d port %h data %h arrived with nothing owed",
					beats_seen, got.kind, got.port, got.data));
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind)
				flag($sformatf("beat %0d: kind %0d, expected %0d", beats_seen, got.kind, want.kind));
			if (got.port !== want.port)
				flag($sformatf("beat %0d: port %h, expected %h", beats_seen, got.port, want.port));
			if (got.data !== want.data)
				flag($sformatf("beat %0d: data %h, expected %h", beats_seen, got.data, want.data));
			if (got.code !== want.code)
				flag($sformatf("beat %0d: code %0d, expected %0d", beats_seen, got.code, want.code));
			if (got.last !== want.last)
				flag($sformatf("beat %0d: last %b, expected %b", beats_seen, got.last, want.last));
		endtask
	endclass

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 item_valid    = 1'b0;
	logic                 item_ready;
	logic [1:0]           req_type      = '0;
	logic                 is_write      = 1'b0;
	logic [1:0]           drive_index   = '0;
	logic [LBA_W-1:0]     block_address = '0;
	logic [WORD_W-1:0]    reply_value   = '0;
	logic [WORD_W-1:0]    write_word    = '0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [POLL_W-1:0]    cfg_data      = '0;
	logic                 result_valid;
	logic                 result_ready  = 1'b0;
	logic [2:0]           result_kind;
	logic [PORT_W-1:0]    bus_port;
	logic [WORD_W-1:0]    out_data;
	logic [2:0]           done_code;
	logic                 last;

	sector_scoreboard sb;
	bit quiet = 1'b0;   // no idling on either side while set
	int hold = 0;
	int idle_cycles = 0;

	ata_pio_sector_sequencer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.req_type      (req_type),
		.is_write      (is_write),
		.drive_index   (drive_index),
		.block_address (block_address),
		.reply_value   (reply_value),
		.write_word    (write_word),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result_kind   (result_kind),
		.bus_port      (bus_port),
		.out_data      (out_data),
		.done_code     (done_code),
		.last          (last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// well-formed traffic for the predicted phase, with some noise mixed in
	function automatic item_t pick_item();
		item_t it;
		it.req   = REQ_CMD;
		it.wr    = 1'($urandom);
		it.drv   = 2'($urandom);
		it.lba   = 28'($urandom);
		it.reply = 16'($urandom);
		it.word  = 16'($urandom);
		if ($urandom_range(0, 99) < 8) begin
			it.req = 2'($urandom);
			return it;
		end
		case (sb.phase)
		S_IDLE:  it.req = REQ_CMD;
		S_WDATA: it.req = REQ_WORD;
		default: begin
			it.req = REQ_REPLY;
			case (sb.phase)
			S_PRESENT: if ($urandom_range(0, 99) < 20) it.reply[7:0] = ST_ABSENT;
			S_BUSY, S_FBUSY: it.reply[ST_BSY_BIT] = ($urandom_range(0, 99) < 45);
			// data phases are a full sector long, so data requests stay rare
			S_DREQ: it.reply[ST_DRQ_BIT] = ($urandom_range(0, 99) < 25);
			default: ;
			endcase
		end
		endcase
		return it;
	endfunction

	task automatic send(input item_t it);
		int gap;
		item_valid    <= 1'b1;
		req_type      <= it.req;
		is_write      <= it.wr;
		drive_index   <= it.drv;
		block_address <= it.lba;
		reply_value   <= it.reply;
		write_word    <= it.word;
		do @(posedge clk); while (!item_ready);
		sb.note_item(it);
		gap = gap_len();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// a fixed number of random items, whatever phase they leave behind
	task automatic run_items(input int n);
		repeat (n) send(pick_item());
	endtask

	// wait for every owed beat, then give the back end time to go quiet
	task automatic settle_down();
		item_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic load_regs(input logic [POLL_W-1:0] limit, input logic [SETTLE_W-1:0] settle);
		logic [CFG_IDX_W-1:0] idx[3];
		logic [POLL_W-1:0]    val[3];
		idx = '{CFG_POLL_LIMIT, CFG_SETTLE_READS, CFG_SPARE};
		val = '{limit, {16'($urandom), settle}, 20'($urandom)};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// result side: random back-pressure and checking of each beat
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(beat_t'{kind: kind_t'(result_kind), port: bus_port, data: out_data,
				code: done_t'(done_code), last: last});
		if (hold == 0)
			hold = gap_len();
		else
			hold--;
		result_ready <= (hold == 0);
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// stray requests while idle
		send(item_t'{REQ_REPLY, 1'b0, 2'd0, 28'd0, 16'hFFFF, 16'h0000});
		send(item_t'{REQ_WORD, 1'b0, 2'd0, 28'd0, 16'h0000, 16'hFFFF});
		send(item_t'{REQ_BAD, 1'b1, 2'd3, 28'hFFFFFFF, 16'hFFFF, 16'hFFFF});
		// read on secondary slave, top address, no drive present
		send(item_t'{REQ_CMD, 1'b0, 2'd3, 28'hFFFFFFF, 16'h0000, 16'h0000});
		send(item_t'{REQ_CMD, 1'b1, 2'd0, 28'd0, 16'h0000, 16'h0000});
		repeat (4) send(item_t'{REQ_REPLY, 1'b0, 2'd0, 28'd0, 16'($urandom), 16'h0000});
		send(item_t'{REQ_REPLY, 1'b0, 2'd0, 28'd0, 16'h00FF, 16'h0000});

		// random traffic over a range of register settings
		run_items(12);
		settle_down();
		load_regs(20'd1, 4'd0);
		run_items(20);
		settle_down();
		load_regs(20'd0, 4'd15);
		run_items(16);
		settle_down();
		quiet = 1'b1;
		load_regs('1, 4'd1);
		run_items(12);
		settle_down();
		quiet = 1'b0;
		load_regs(20'($urandom_range(2, 5)), 4'($urandom_range(0, 15)));
		run_items(20);
		settle_down();

		// write on primary master: busy once, no data request once, then data
		load_regs(POLL_LIMIT_RST, SETTLE_READS_RST);
		send(item_t'{REQ_CMD, 1'b1, 2'd0, 28'd0, 16'h0000, 16'h0000});
		repeat (4) send(item_t'{REQ_REPLY, 1'b0, 2'd0, 28'd0, 16'($urandom), 16'h0000});
		send(item_t'{REQ_REPLY, 1'b0, 2'd0, 28'd0, 16'hFFFF, 16'h0000});
		send(item_t'{REQ_REPLY, 1'b0, 2'd0, 28'd0, 16'h0000, 16'h0000});
		send(item_t'{REQ_REPLY, 1'b0, 2'd0, 28'd0, 16'hFFF7, 16'h0000});
		send(item_t'{REQ_REPLY, 1'b0, 2'd0, 28'd0, 16'h0008, 16'h0000});
		send(item_t'{REQ_WORD, 1'b0, 2'd0, 28'd0, 16'h0000, 16'hFFFF});
		send(item_t'{REQ_WORD, 1'b0, 2'd0, 28'd0, 16'h0000, 16'h0000});
		send(item_t'{REQ_CMD, 1'b0, 2'd2, 28'd5, 16'h0000, 16'h0000});
		send(item_t'{REQ_REPLY, 1'b0, 2'd0, 28'd0, 16'h0080, 16'h0000});
		settle_down();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
